FILE: hw/rtl/tgel_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgel_pkg: shared definitions for the two-group exclusion lock
// Default sizes, command and status codes, and the count limit.
// ----------------------------------------------------------------------------
package tgel_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    localparam int CNT_W     = 9;
    localparam int COUNT_MAX = 256;

    typedef logic [1:0] cmd_t;
    typedef logic [2:0] status_t;

    localparam cmd_t CMD_ENTER    = 2'd0;
    localparam cmd_t CMD_LEAVE    = 2'd1;
    localparam cmd_t CMD_WITHDRAW = 2'd2;

    localparam status_t ST_GRANTED     = 3'd0;
    localparam status_t ST_QUEUED      = 3'd1;
    localparam status_t ST_GRANTED_Q   = 3'd2;
    localparam status_t ST_LEFT        = 3'd3;
    localparam status_t ST_WITHDRAWN   = 3'd4;
    localparam status_t ST_NOT_FOUND   = 3'd5;
    localparam status_t ST_FULL        = 3'd6;
    localparam status_t ST_LEAVE_ERROR = 3'd7;

endpackage
`default_nettype wire

FILE: hw/rtl/tgel_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgel_req_if / tgel_rsp_if: request and response channels
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface tgel_req_if #(
    parameter int ID_BITS = tgel_pkg::ID_BITS_DEF
);
    logic                valid;
    logic                ready;
    tgel_pkg::cmd_t      cmd;
    logic                group;
    logic [ID_BITS-1:0]  requester;
    logic                has_timeout;

    modport source (output valid, cmd, group, requester, has_timeout, input ready);
    modport sink   (input valid, cmd, group, requester, has_timeout, output ready);
endinterface

interface tgel_rsp_if #(
    parameter int ID_BITS = tgel_pkg::ID_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    tgel_pkg::status_t            status;
    logic [ID_BITS-1:0]           who;
    logic                         which_group;
    logic                         cancel_timer;
    logic [tgel_pkg::CNT_W-1:0]   inside_now;
    logic                         last;

    modport source (output valid, status, who, which_group, cancel_timer, inside_now, last,
                    input ready);
    modport sink   (input valid, status, who, which_group, cancel_timer, inside_now, last,
                    output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/tgel_slot_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgel_slot_unit: shared queue address and match unit
// Maps a queue offset to a circular slot and compares a read entry to the key.
// ----------------------------------------------------------------------------
module tgel_slot_unit #(
    parameter int QUEUE_DEPTH = tgel_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = tgel_pkg::ID_BITS_DEF
) (
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0]   head,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0] offset,
    input  wire logic [ID_BITS:0]                 entry,
    input  wire logic [ID_BITS-1:0]               key,
    output logic      [$clog2(QUEUE_DEPTH)-1:0]   slot,
    output logic                                  match
);

    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = LW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);

    logic [SW-1:0] sum;
    logic [SW-1:0] wrapped;

    always_comb
    begin
        sum     = SW'(head) + SW'(offset);
        wrapped = (sum >= DEPTH_S) ? (sum - DEPTH_S) : sum;
        slot    = wrapped[HW-1:0];
        match   = entry[ID_BITS] && (entry[ID_BITS-1:0] == key);
    end

endmodule
`default_nettype wire

FILE: hw/rtl/two_group_exclusion_lock.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_group_exclusion_lock: two-group mutual exclusion lock
// Sequencer, wait queue memory, counters and response register.
// ----------------------------------------------------------------------------
// Requesters of group 0 or group 1 enter, leave, or are withdrawn from a wait
// queue after a timeout; only one group is inside at a time. Each group has a
// circular FIFO of QUEUE_DEPTH entries in one single-port-style memory.
// Enqueue and withdraw addressing goes through one shared slot/compare unit
// (admission reads the head slot directly), and the block takes one request
// at a time. An enter or a plain leave can be held by response backpressure.
// A leave that admits n waiters does one memory read and one response per
// waiter. A withdraw walks queue 0 then queue 1, reading and comparing each
// entry inspected, then moves every later entry up (read, write). The
// response register lets a new request be taken while a response waits.
// The memory needs no clearing; only entries inside a queue are read.
// ----------------------------------------------------------------------------
module two_group_exclusion_lock #(
    parameter int QUEUE_DEPTH = tgel_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = tgel_pkg::ID_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tgel_req_if.sink   req,
    tgel_rsp_if.source rsp
);

    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = HW + 1;
    localparam int EW = ID_BITS + 1;
    localparam int CW = tgel_pkg::CNT_W;
    localparam logic [LW-1:0] DEPTH_L   = LW'(QUEUE_DEPTH);
    localparam logic [HW-1:0] HEAD_LAST = HW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX_C = CW'(tgel_pkg::COUNT_MAX);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_EMIT     = 4'd2;
    localparam logic [3:0] S_ADM_RD   = 4'd3;
    localparam logic [3:0] S_ADM_EMIT = 4'd4;
    localparam logic [3:0] S_WD_RD    = 4'd5;
    localparam logic [3:0] S_WD_CMP   = 4'd6;
    localparam logic [3:0] S_MV_RD    = 4'd7;
    localparam logic [3:0] S_MV_WR    = 4'd8;

    logic [3:0] state_reg, state_next;

    tgel_pkg::cmd_t     cmd_reg, cmd_next;
    logic               grp_reg, grp_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic               tmo_reg, tmo_next;

    logic [CW-1:0] cnt_reg  [2];
    logic [CW-1:0] cnt_next [2];
    logic [HW-1:0] head_reg  [2];
    logic [HW-1:0] head_next [2];
    logic [LW-1:0] len_reg  [2];
    logic [LW-1:0] len_next [2];

    logic          q_reg, q_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [LW-1:0] adm_reg, adm_next;

    tgel_pkg::status_t  res_status_reg, res_status_next;
    logic [ID_BITS-1:0] res_who_reg, res_who_next;
    logic               res_grp_reg, res_grp_next;
    logic [CW-1:0]      res_inside_reg, res_inside_next;

    logic               ov_reg, ov_next;
    tgel_pkg::status_t  ostat_reg, ostat_next;
    logic [ID_BITS-1:0] owho_reg, owho_next;
    logic               ogrp_reg, ogrp_next;
    logic               ocancel_reg, ocancel_next;
    logic [CW-1:0]      oinside_reg, oinside_next;
    logic               olast_reg, olast_next;

    logic [EW-1:0] mem [2**AW];
    logic [EW-1:0] rd_data_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] mem_wdata;

    logic          su_grp;
    logic [HW-1:0] su_head;
    logic [LW-1:0] su_off;
    logic [HW-1:0] su_slot;
    logic          su_match;

    logic          oth;
    logic          out_free;
    logic [LW-1:0] idx_inc;
    logic [CW-1:0] room;
    logic [LW-1:0] adm_n;
    logic [CW-1:0] cnt_dec;

    tgel_slot_unit #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_slot (
        .head   (su_head),
        .offset (su_off),
        .entry  (rd_data_reg),
        .key    (id_reg),
        .slot   (su_slot),
        .match  (su_match)
    );

    assign oth      = ~grp_reg;
    assign out_free = !ov_reg || rsp.ready;
    assign idx_inc  = idx_reg + 1'b1;
    assign room     = CNT_MAX_C - cnt_reg[oth];
    assign adm_n    = (CW'(len_reg[oth]) < room) ? len_reg[oth] : LW'(room);
    assign cnt_dec  = cnt_reg[grp_reg] - 1'b1;

    // shared unit operand select
    always_comb
    begin
        su_grp = (state_reg == S_DECODE) ? grp_reg : q_reg;
        su_head = head_reg[su_grp];
        case (state_reg)
            S_DECODE: su_off = len_reg[grp_reg];
            S_MV_RD:  su_off = idx_inc;
            default:  su_off = idx_reg;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        grp_next        = grp_reg;
        id_next         = id_reg;
        tmo_next        = tmo_reg;
        cnt_next        = cnt_reg;
        head_next       = head_reg;
        len_next        = len_reg;
        q_next          = q_reg;
        idx_next        = idx_reg;
        adm_next        = adm_reg;
        res_status_next = res_status_reg;
        res_who_next    = res_who_reg;
        res_grp_next    = res_grp_reg;
        res_inside_next = res_inside_reg;
        ov_next         = ov_reg && !rsp.ready;
        ostat_next      = ostat_reg;
        owho_next       = owho_reg;
        ogrp_next       = ogrp_reg;
        ocancel_next    = ocancel_reg;
        oinside_next    = oinside_reg;
        olast_next      = olast_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = {su_grp, su_slot};
        mem_raddr       = {su_grp, su_slot};
        mem_wdata       = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.cmd;
                    grp_next   = req.group;
                    id_next    = req.requester;
                    tmo_next   = req.has_timeout;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_who_next = id_reg;
                res_grp_next = grp_reg;
                case (cmd_reg)
                    tgel_pkg::CMD_ENTER:
                    begin
                        state_next = S_EMIT;
                        if (cnt_reg[oth] != '0 || len_reg[oth] != '0)
                        begin
                            res_inside_next = cnt_reg[grp_reg];
                            if (len_reg[grp_reg] == DEPTH_L)
                            begin
                                res_status_next = tgel_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we                 = 1'b1;
                                mem_wdata              = {tmo_reg, id_reg};
                                len_next[grp_reg]      = len_reg[grp_reg] + 1'b1;
                                res_status_next        = tgel_pkg::ST_QUEUED;
                            end
                        end
                        else if (cnt_reg[grp_reg] == CNT_MAX_C)
                        begin
                            res_status_next = tgel_pkg::ST_FULL;
                            res_inside_next = cnt_reg[grp_reg];
                        end
                        else
                        begin
                            cnt_next[grp_reg] = cnt_reg[grp_reg] + 1'b1;
                            res_status_next   = tgel_pkg::ST_GRANTED;
                            res_inside_next   = cnt_reg[grp_reg] + 1'b1;
                        end
                    end

                    tgel_pkg::CMD_LEAVE:
                    begin
                        if (cnt_reg[grp_reg] == '0)
                        begin
                            res_status_next = tgel_pkg::ST_LEAVE_ERROR;
                            res_inside_next = '0;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            cnt_next[grp_reg] = cnt_dec;
                            if (cnt_dec == '0 && len_reg[oth] != '0 &&
                                cnt_reg[oth] != CNT_MAX_C)
                            begin
                                cnt_next[oth] = cnt_reg[oth] + CW'(adm_n);
                                adm_next      = adm_n;
                                state_next    = S_ADM_RD;
                            end
                            else
                            begin
                                res_status_next = tgel_pkg::ST_LEFT;
                                res_inside_next = cnt_dec;
                                state_next      = S_EMIT;
                            end
                        end
                    end

                    tgel_pkg::CMD_WITHDRAW:
                    begin
                        q_next     = 1'b0;
                        idx_next   = '0;
                        state_next = S_WD_RD;
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    ostat_next   = res_status_reg;
                    owho_next    = res_who_reg;
                    ogrp_next    = res_grp_reg;
                    ocancel_next = 1'b0;
                    oinside_next = res_inside_reg;
                    olast_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            S_ADM_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = {oth, head_reg[oth]};
                state_next = S_ADM_EMIT;
            end

            S_ADM_EMIT:
            begin
                if (out_free)
                begin
                    ov_next        = 1'b1;
                    ostat_next     = tgel_pkg::ST_GRANTED_Q;
                    owho_next      = rd_data_reg[ID_BITS-1:0];
                    ogrp_next      = oth;
                    ocancel_next   = rd_data_reg[ID_BITS];
                    oinside_next   = cnt_reg[oth];
                    olast_next     = (adm_reg == LW'(1));
                    head_next[oth] = (head_reg[oth] == HEAD_LAST) ? '0 :
                                     head_reg[oth] + 1'b1;
                    len_next[oth]  = len_reg[oth] - 1'b1;
                    adm_next       = adm_reg - 1'b1;
                    state_next     = (adm_reg == LW'(1)) ? S_IDLE : S_ADM_RD;
                end
            end

            S_WD_RD:
            begin
                if (idx_reg == len_reg[q_reg])
                begin
                    if (!q_reg)
                    begin
                        q_next   = 1'b1;
                        idx_next = '0;
                    end
                    else
                    begin
                        res_status_next = tgel_pkg::ST_NOT_FOUND;
                        res_who_next    = id_reg;
                        res_grp_next    = grp_reg;
                        res_inside_next = cnt_reg[grp_reg];
                        state_next      = S_EMIT;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_WD_CMP;
                end
            end

            S_WD_CMP:
            begin
                if (su_match)
                begin
                    state_next = S_MV_RD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_WD_RD;
                end
            end

            S_MV_RD:
            begin
                if (idx_inc < len_reg[q_reg])
                begin
                    mem_re     = 1'b1;
                    state_next = S_MV_WR;
                end
                else
                begin
                    len_next[q_reg] = len_reg[q_reg] - 1'b1;
                    res_status_next = tgel_pkg::ST_WITHDRAWN;
                    res_who_next    = id_reg;
                    res_grp_next    = q_reg;
                    res_inside_next = cnt_reg[q_reg];
                    state_next      = S_EMIT;
                end
            end

            S_MV_WR:
            begin
                mem_we     = 1'b1;
                idx_next   = idx_inc;
                state_next = S_MV_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '{default: '0};
            head_reg  <= '{default: '0};
            len_reg   <= '{default: '0};
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            head_reg  <= head_next;
            len_reg   <= len_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        grp_reg        <= grp_next;
        id_reg         <= id_next;
        tmo_reg        <= tmo_next;
        q_reg          <= q_next;
        idx_reg        <= idx_next;
        adm_reg        <= adm_next;
        res_status_reg <= res_status_next;
        res_who_reg    <= res_who_next;
        res_grp_reg    <= res_grp_next;
        res_inside_reg <= res_inside_next;
        ostat_reg      <= ostat_next;
        owho_reg       <= owho_next;
        ogrp_reg       <= ogrp_next;
        ocancel_reg    <= ocancel_next;
        oinside_reg    <= oinside_next;
        olast_reg      <= olast_next;
    end

    // wait queue storage, both groups
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = ov_reg;
    assign rsp.status       = ostat_reg;
    assign rsp.who          = owho_reg;
    assign rsp.which_group  = ogrp_reg;
    assign rsp.cancel_timer = ocancel_reg;
    assign rsp.inside_now   = oinside_reg;
    assign rsp.last         = olast_reg;

endmodule
`default_nettype wire
